### src/ogm_pkg.sv
// ogm_pkg: shared types and codes for the occupancy grid map.
// No dependencies.
`default_nettype none

package ogm_pkg;

    typedef enum logic [2:0] {
        MODE_FREE    = 3'd0,
        MODE_OCC     = 3'd1,
        MODE_READ    = 3'd2,
        MODE_LOAD    = 3'd3,
        MODE_CONSUME = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CELL_UNKNOWN  = 2'd0,
        CELL_FREE     = 2'd1,
        CELL_OCCUPIED = 2'd2
    } t_cell;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam int unsigned DIM_W   = 9;
    localparam int unsigned COORD_W = 11;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned REV_W   = 64;

endpackage

`default_nettype wire

### src/occupancy_grid_map.sv
// occupancy_grid_map: three-state cell grid in one synchronous RAM, read-modify-write.
// Depends on ogm_pkg.
// Pipeline: stage-1 index registers, stage-2 registers and RAM read, output register.
// Throughput: one word per cycle if not stalled; the RAM read and the write-back of
// the previous word overlap, with a forwarding register for back-to-back hits on one
// cell. Reset: after reset a clearing pass writes unknown to all MAX_COLS*MAX_ROWS
// cells, one per cycle, with o_in_stall high; config writes are taken throughout.
`default_nettype none

module occupancy_grid_map
    import ogm_pkg::*;
#(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [DIM_W-1:0]          i_cfg_data,

    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_in_mode,
    input  wire logic signed [COORD_W-1:0] i_in_col,
    input  wire logic signed [COORD_W-1:0] i_in_row,
    input  wire logic [1:0]                i_in_cell_value,
    input  wire logic                      i_in_last,

    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_out_cell_state,
    output logic                           o_out_in_grid,
    output logic                           o_out_changed,
    output logic                           o_out_was_dirty,
    output logic [COUNT_W-1:0]             o_out_explored_count,
    output logic [REV_W-1:0]               o_out_revision
);

    localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0] r_mem [DEPTH];

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic          clr_en;

    logic [DIM_W-1:0] r_width, r_height;

    // stage 1: index computed
    logic          r_s1_valid;
    t_mode         r_s1_mode;
    logic          r_s1_inside;
    logic [AW-1:0] r_s1_idx;
    logic [1:0]    r_s1_val;
    logic          r_s1_last;

    // stage 2: RAM data available
    logic          r_s2_valid;
    t_mode         r_s2_mode;
    logic          r_s2_inside;
    logic [AW-1:0] r_s2_idx;
    logic [1:0]    r_s2_val;
    logic          r_s2_last;
    logic [1:0]    r_rdata;

    logic          r_fw_valid;
    logic [AW-1:0] r_fw_idx;
    logic [1:0]    r_fw_data;

    logic               r_dirty;
    logic [REV_W-1:0]   r_revision;
    logic [COUNT_W-1:0] r_explored;

    logic adv, accept, fire;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             in_inside;
    logic [18:0]      in_prod;
    logic [19:0]      in_sum;
    logic [AW-1:0]    in_idx;

    logic [1:0]         s2_cur, s2_new;
    logic               s2_wr;
    logic               n_dirty;
    logic               rev_inc;
    logic [REV_W-1:0]   n_revision;
    logic [COUNT_W-1:0] n_explored;

    // clearing sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        clr_en  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_en = 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                clr_en = 1'b0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(256);
            r_height <= DIM_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_height <= i_cfg_data;
                default:         r_width  <= r_width;
            endcase
        end
    end

    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_CLEAR) || !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign fire       = adv && r_s2_valid;

    // address stage
    always_comb begin
        w_eff = (11'(r_width) > 11'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_width;
        h_eff = (11'(r_height) > 11'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_height;
        in_inside = !i_in_col[COORD_W-1] && !i_in_row[COORD_W-1]
                    && ({1'b0, i_in_col[COORD_W-2:0]} < 11'(w_eff))
                    && ({1'b0, i_in_row[COORD_W-2:0]} < 11'(h_eff));
        in_prod = i_in_row[COORD_W-2:0] * w_eff;
        in_sum  = 20'(in_prod) + 20'(i_in_col[COORD_W-2:0]);
        in_idx  = in_inside ? AW'(in_sum) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            o_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode   <= t_mode'(i_in_mode);
            r_s1_inside <= in_inside;
            r_s1_idx    <= in_idx;
            r_s1_val    <= i_in_cell_value;
            r_s1_last   <= i_in_last;
            r_s2_mode   <= r_s1_mode;
            r_s2_inside <= r_s1_inside;
            r_s2_idx    <= r_s1_idx;
            r_s2_val    <= r_s1_val;
            r_s2_last   <= r_s1_last;
        end
    end

    // cell RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (clr_en) begin
            r_mem[r_clr_addr] <= CELL_UNKNOWN;
        end else if (fire && s2_wr) begin
            r_mem[r_s2_idx] <= s2_new;
        end
        if (adv) begin
            r_rdata <= r_mem[r_s1_idx];
        end
    end

    // forward the latest write; the RAM read of the next word misses it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (fire && s2_wr) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && s2_wr) begin
            r_fw_idx  <= r_s2_idx;
            r_fw_data <= s2_new;
        end
    end

    // modify stage
    always_comb begin
        s2_cur = CELL_UNKNOWN;
        if (r_s2_inside) begin
            s2_cur = (r_fw_valid && r_fw_idx == r_s2_idx) ? r_fw_data : r_rdata;
        end
        s2_wr   = 1'b0;
        s2_new  = s2_cur;
        n_dirty = r_dirty;
        rev_inc = 1'b0;
        case (r_s2_mode)
            MODE_FREE: begin
                s2_new = CELL_FREE;
                s2_wr  = r_s2_inside && (s2_cur == CELL_UNKNOWN);
                if (s2_wr) begin
                    n_dirty = 1'b1;
                    rev_inc = 1'b1;
                end
            end
            MODE_OCC: begin
                s2_new = CELL_OCCUPIED;
                s2_wr  = r_s2_inside && (s2_cur != CELL_OCCUPIED);
                if (s2_wr) begin
                    n_dirty = 1'b1;
                    rev_inc = 1'b1;
                end
            end
            MODE_LOAD: begin
                s2_new = r_s2_val;
                s2_wr  = r_s2_inside && (r_s2_val <= CELL_OCCUPIED) && (r_s2_val != s2_cur);
                if (r_s2_last) begin
                    n_dirty = 1'b0;
                    rev_inc = 1'b1;
                end
            end
            MODE_CONSUME: begin
                n_dirty = 1'b0;
            end
            default: begin
                s2_wr = 1'b0;
            end
        endcase
        n_revision = r_revision + REV_W'(rev_inc);
        n_explored = r_explored;
        if (s2_wr) begin
            n_explored = r_explored + COUNT_W'(s2_new != CELL_UNKNOWN)
                         - COUNT_W'(s2_cur != CELL_UNKNOWN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty    <= 1'b0;
            r_revision <= '0;
            r_explored <= '0;
        end else if (fire) begin
            r_dirty    <= n_dirty;
            r_revision <= n_revision;
            r_explored <= n_explored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_out_cell_state     <= s2_wr ? s2_new : s2_cur;
            o_out_in_grid        <= r_s2_inside;
            o_out_changed        <= s2_wr;
            o_out_was_dirty      <= r_dirty;
            o_out_explored_count <= n_explored;
            o_out_revision       <= n_revision;
        end
    end

endmodule

`default_nettype wire

### src/ogm_checker.sv
// ogm_checker: port-level assertions for occupancy_grid_map, bound to each instance.
// Depends on ogm_pkg and occupancy_grid_map.
`default_nettype none

module ogm_checker
    import ogm_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_cfg_valid,
    input wire logic                      o_cfg_ready,
    input wire logic                      i_cfg_index,
    input wire logic [DIM_W-1:0]          i_cfg_data,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic [2:0]                i_in_mode,
    input wire logic signed [COORD_W-1:0] i_in_col,
    input wire logic signed [COORD_W-1:0] i_in_row,
    input wire logic [1:0]                i_in_cell_value,
    input wire logic                      i_in_last,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [1:0]                o_out_cell_state,
    input wire logic                      o_out_in_grid,
    input wire logic                      o_out_changed,
    input wire logic                      o_out_was_dirty,
    input wire logic [COUNT_W-1:0]        o_out_explored_count,
    input wire logic [REV_W-1:0]          o_out_revision
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_revision)
            && $stable(o_out_cell_state) && $stable(o_out_explored_count))
        else $error("stalled output word changed");

    a_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_in_grid |-> o_out_cell_state == CELL_UNKNOWN && !o_out_changed)
        else $error("cell outside grid reported state or change");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not idle and clearing after reset");

endmodule

bind occupancy_grid_map ogm_checker u_ogm_checker (.*);

`default_nettype wire

### test/tb_occupancy_grid_map.sv
// tb_occupancy_grid_map: self-checking testbench for the occupancy grid map.
// Directed cases and random traffic are checked against a predictor of the grid.
// Depends on ogm_pkg and occupancy_grid_map.

module tb_occupancy_grid_map;
    import ogm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_COLS         = 256;
    localparam int unsigned MAX_ROWS         = 256;
    localparam int unsigned PIPE_LATENCY     = 3;
    localparam int unsigned CYCLE_LIMIT      = 800000;
    localparam int unsigned RANDOM_PER_PHASE = 62;

    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [1:0] CELL_BAD     = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] col;
        logic [10:0] row;
        logic [1:0]  value;
        logic        last;
    } grid_op_t;

    typedef struct packed {
        logic [1:0]         cell_state;
        logic               in_grid;
        logic               changed;
        logic               was_dirty;
        logic [COUNT_W-1:0] explored_count;
        logic [REV_W-1:0]   revision;
    } grid_reply_t;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      i_cfg_index = REG_GRID_WIDTH;
    logic [DIM_W-1:0]          i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic [2:0]                i_in_mode = MODE_READ;
    logic signed [COORD_W-1:0] i_in_col = '0;
    logic signed [COORD_W-1:0] i_in_row = '0;
    logic [1:0]                i_in_cell_value = CELL_UNKNOWN;
    logic                      i_in_last = 1'b0;
    logic                      i_out_stall = 1'b0;

    logic                      o_cfg_ready;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [1:0]                o_out_cell_state;
    logic                      o_out_in_grid;
    logic                      o_out_changed;
    logic                      o_out_was_dirty;
    logic [COUNT_W-1:0]        o_out_explored_count;
    logic [REV_W-1:0]          o_out_revision;

    occupancy_grid_map #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_in_mode            (i_in_mode),
        .i_in_col             (i_in_col),
        .i_in_row             (i_in_row),
        .i_in_cell_value      (i_in_cell_value),
        .i_in_last            (i_in_last),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_cell_state     (o_out_cell_state),
        .o_out_in_grid        (o_out_in_grid),
        .o_out_changed        (o_out_changed),
        .o_out_was_dirty      (o_out_was_dirty),
        .o_out_explored_count (o_out_explored_count),
        .o_out_revision       (o_out_revision)
    );

    // grid predictor state
    logic [1:0]       cell_mdl [0:MAX_COLS*MAX_ROWS-1];
    int unsigned      explored_mdl = 0;
    logic [REV_W-1:0] revision_mdl = '0;
    logic             dirty_mdl = 1'b0;
    logic [DIM_W-1:0] width_mdl = 9'd256;
    logic [DIM_W-1:0] height_mdl = 9'd256;

    grid_reply_t  expected_replies [$];
    int unsigned  error_count = 0;
    int unsigned  words_sent = 0;
    int unsigned  replies_checked = 0;
    int unsigned  geometries = 0;
    int unsigned  load_runs = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  stall_span = 0;
    stall_style_t stall_style = STALL_NONE;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                     expected_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_span  = $urandom_range(16, 96);
        end
        stall_span--;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 4) == 0);
            STALL_PERIODIC: i_out_stall <= ((stall_span % 9) < 4);
            default:        i_out_stall <= ($urandom_range(0, 1) == 1);
        endcase
    end

    task automatic report_error(input string msg);
        if (error_count < 40)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
            report_error($sformatf("reply %0d %s: expected %0h got %0h",
                                   replies_checked, name, exp_v, got_v));
    endtask

    always @(posedge i_clk) begin
        grid_reply_t exp_r;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                report_error("reply word with nothing expected");
            end else begin
                exp_r = expected_replies.pop_front();
                check_field("cell_state", 64'(exp_r.cell_state), 64'(o_out_cell_state));
                check_field("in_grid", 64'(exp_r.in_grid), 64'(o_out_in_grid));
                check_field("changed", 64'(exp_r.changed), 64'(o_out_changed));
                check_field("was_dirty", 64'(exp_r.was_dirty), 64'(o_out_was_dirty));
                check_field("explored_count", 64'(exp_r.explored_count),
                            64'(o_out_explored_count));
                check_field("revision", exp_r.revision, o_out_revision);
                replies_checked++;
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d, input int unsigned lim);
        return (d > lim) ? lim : d;
    endfunction

    function automatic void store_cell(input int unsigned idx, input logic [1:0] v);
        if (cell_mdl[idx] != CELL_UNKNOWN)
            explored_mdl--;
        if (v != CELL_UNKNOWN)
            explored_mdl++;
        cell_mdl[idx] = v;
    endfunction

    function automatic grid_reply_t apply_grid_op(input grid_op_t op);
        int          w;
        int          h;
        int          c;
        int          r;
        int unsigned idx;
        logic        in_area;
        logic [1:0]  cur;
        grid_reply_t rp;
        w       = clamp_dim(width_mdl, MAX_COLS);
        h       = clamp_dim(height_mdl, MAX_ROWS);
        c       = int'($signed(op.col));
        r       = int'($signed(op.row));
        in_area = (c >= 0) && (r >= 0) && (c < w) && (r < h);
        idx     = in_area ? (r * w + c) : 0;
        cur     = in_area ? cell_mdl[idx] : CELL_UNKNOWN;
        rp      = '0;
        rp.was_dirty = dirty_mdl;
        case (op.mode)
            MODE_FREE: begin
                if (in_area && cur == CELL_UNKNOWN) begin
                    store_cell(idx, CELL_FREE);
                    rp.changed = 1'b1;
                end
            end
            MODE_OCC: begin
                if (in_area && cur != CELL_OCCUPIED) begin
                    store_cell(idx, CELL_OCCUPIED);
                    rp.changed = 1'b1;
                end
            end
            MODE_LOAD: begin
                if (in_area && op.value != CELL_BAD && op.value != cur) begin
                    store_cell(idx, op.value);
                    rp.changed = 1'b1;
                end
                if (op.last) begin
                    dirty_mdl    = 1'b0;
                    revision_mdl = revision_mdl + 1'b1;
                end
            end
            MODE_CONSUME: dirty_mdl = 1'b0;
            default: ;
        endcase
        if (rp.changed && (op.mode == MODE_FREE || op.mode == MODE_OCC)) begin
            dirty_mdl    = 1'b1;
            revision_mdl = revision_mdl + 1'b1;
        end
        rp.cell_state     = in_area ? cell_mdl[idx] : CELL_UNKNOWN;
        rp.in_grid        = in_area;
        rp.explored_count = COUNT_W'(explored_mdl);
        rp.revision       = revision_mdl;
        return rp;
    endfunction

    function automatic grid_op_t make_op(input logic [2:0] mode, input int col, input int row,
                                         input logic [1:0] value, input logic last);
        grid_op_t op;
        op.mode  = mode;
        op.col   = col[10:0];
        op.row   = row[10:0];
        op.value = value;
        op.last  = last;
        return op;
    endfunction

    task automatic send_word(input grid_op_t op);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid      <= 1'b1;
        i_in_mode       <= op.mode;
        i_in_col        <= op.col;
        i_in_row        <= op.row;
        i_in_cell_value <= op.value;
        i_in_last       <= op.last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_replies.push_back(apply_grid_op(op));
        burst_left--;
        words_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        width_mdl = w;
        i_cfg_index <= REG_GRID_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        height_mdl = h;
        i_cfg_valid <= 1'b0;
        geometries++;
    endtask

    // mostly inside the grid, some just past an edge, some anywhere
    function automatic int pick_coord(input int unsigned dim);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 78)
            return (dim == 0) ? $urandom_range(0, 3) : $urandom_range(0, dim - 1);
        else if (sel < 86)
            return dim;
        else if (sel < 92)
            return -1;
        return $signed(11'($urandom_range(0, 2047)));
    endfunction

    task automatic test_default_grid();
        send_word(make_op(MODE_READ, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_FREE, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_FREE, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_OCC, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_OCC, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_CONSUME, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_CONSUME, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_OCC, 255, 255, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_READ, 256, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_OCC, -1024, 1023, CELL_OCCUPIED, 1'b1));
        send_word(make_op(MODE_FREE, 1023, -1024, CELL_BAD, 1'b0));
        send_word(make_op(MODE_LOAD, 255, 255, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_LOAD, 0, 0, CELL_OCCUPIED, 1'b0));
        send_word(make_op(MODE_LOAD, 0, 1, CELL_BAD, 1'b1));
        send_word(make_op(MODE_LOAD, -1, 5, CELL_FREE, 1'b1));
        send_word(make_op(MODE_SPARE_5, 0, 0, CELL_FREE, 1'b1));
        send_word(make_op(MODE_SPARE_7, 255, 0, CELL_OCCUPIED, 1'b0));
    endtask

    task automatic test_clamped_grid();
        set_geometry(9'd511, 9'd511);
        send_word(make_op(MODE_FREE, 255, 255, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_OCC, 256, 256, CELL_UNKNOWN, 1'b0));
    endtask

    task automatic test_empty_grid();
        set_geometry(9'd0, 9'd256);
        send_word(make_op(MODE_OCC, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_LOAD, 0, 0, CELL_FREE, 1'b1));
        set_geometry(9'd256, 9'd0);
        send_word(make_op(MODE_FREE, 0, 0, CELL_UNKNOWN, 1'b0));
    endtask

    // 1x1 grid: cell 0 is shared with the full-size layout
    task automatic test_single_cell_grid();
        set_geometry(9'd1, 9'd1);
        send_word(make_op(MODE_READ, 0, 0, CELL_UNKNOWN, 1'b0));
        send_word(make_op(MODE_FREE, 1, 0, CELL_UNKNOWN, 1'b0));
    endtask

    task automatic send_random_word();
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned len;
        w    = clamp_dim(width_mdl, MAX_COLS);
        h    = clamp_dim(height_mdl, MAX_ROWS);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_word(make_op($urandom_range(0, 1) ? MODE_OCC : MODE_FREE, pick_coord(w),
                              pick_coord(h), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end else if (pick < 38) begin
            send_word(make_op(MODE_READ, pick_coord(w), pick_coord(h),
                              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end else if (pick < 65) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_word(make_op(MODE_LOAD, pick_coord(w), pick_coord(h),
                                  ($urandom_range(0, 9) == 0) ? CELL_BAD
                                                              : 2'($urandom_range(0, 2)),
                                  (k == len - 1)));
            load_runs++;
        end else if (pick < 75) begin
            send_word(make_op(MODE_CONSUME, pick_coord(w), pick_coord(h),
                              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end else begin
            send_word(make_op(3'($urandom_range(0, 7)), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_random_traffic();
        logic [DIM_W-1:0] widths  [0:11];
        logic [DIM_W-1:0] heights [0:11];
        int unsigned      start;
        widths  = '{9'd4, 9'd1, 9'd256, 9'd7, 9'd16, 9'd0, 9'd256, 9'd511, 9'd3, 9'd12,
                    9'($urandom_range(1, 24)), 9'($urandom_range(0, 511))};
        heights = '{9'd4, 9'd256, 9'd1, 9'd3, 9'd16, 9'd9, 9'd256, 9'd300, 9'd200, 9'd5,
                    9'($urandom_range(1, 24)), 9'($urandom_range(0, 511))};
        for (int p = 0; p < 12; p++) begin
            set_geometry(widths[p], heights[p]);
            start = words_sent;
            while (words_sent - start < RANDOM_PER_PHASE)
                send_random_word();
        end
    endtask

    initial begin
        foreach (cell_mdl[i])
            cell_mdl[i] = CELL_UNKNOWN;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_grid();
        test_clamped_grid();
        test_empty_grid();
        test_single_cell_grid();
        test_random_traffic();
        wait_idle();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);
        if (expected_replies.size() != 0)
            report_error($sformatf("%0d replies never arrived", expected_replies.size()));
        $display("Checked %0d replies for %0d words over %0d geometry settings",
                 replies_checked, words_sent, geometries);
        $display("Load runs %0d, final revision %0d, explored cells %0d, errors %0d",
                 load_runs, revision_mdl, explored_mdl, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
